@@ rtl/threshold_quantize_bitplane_pack_macros.svh @@
// Assertion macros shared by the threshold quantise / bit-plane pack RTL.
`ifndef THRESHOLD_QUANTIZE_BITPLANE_PACK_MACROS_SVH
`define THRESHOLD_QUANTIZE_BITPLANE_PACK_MACROS_SVH

// Checked on every clock edge outside reset.
`define TQBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TQBP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tqbp_pkg.sv @@
// Types and constants of the threshold quantise / bit-plane pack block.
package tqbp_pkg;

   localparam int DATA_W       = 32;
   localparam int IDX_W        = 4;
   localparam int CODE_W       = 4;
   localparam int TABLE_DEPTH  = 16;
   localparam int TABLE_KMAX   = 4;   // a 16-entry table holds at most 4-bit codes
   localparam int PLANE_W      = 2;
   localparam int WIDX_W       = 5;
   localparam int GRP_W        = 5;   // 32 samples per packed word
   localparam int WORD_W       = 32;
   localparam int BITS_CFG_W   = 3;
   localparam int LEN_CFG_W    = 11;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 40;

   localparam int MAX_BITS_DEF   = 4;
   localparam int MAX_LENGTH_DEF = 1024;

   localparam logic [BITS_CFG_W-1:0] BITS_USED_RST     = 3'd1;
   localparam logic [LEN_CFG_W-1:0]  VECTOR_LENGTH_RST = 11'd1024;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_BITS_USED     = 1'b0,
      REG_VECTOR_LENGTH = 1'b1
   } reg_type;

   typedef enum logic {
      OP_TABLE_WRITE = 1'b0,
      OP_SAMPLE      = 1'b1
   } op_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] thr;
      logic [CODE_W-1:0] code;
   } tbl_wr_type;

endpackage

@@ rtl/tqbp_level.sv @@
// Threshold and code tables with the parallel level search and code lookup.
module tqbp_level (
   input  logic                                  clock,
   input  tqbp_pkg::tbl_wr_type                  tbl_wr,
   input  logic [tqbp_pkg::DATA_W-1:0]           sample,
   input  logic [tqbp_pkg::BITS_CFG_W-1:0]       k_eff,
   output logic [tqbp_pkg::CODE_W-1:0]           code
);
   import tqbp_pkg::*;

   logic [DATA_W-1:0] thr_ff  [TABLE_DEPTH];
   logic [CODE_W-1:0] code_ff [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] below;
   logic [IDX_W-1:0]       level;
   logic [IDX_W:0]         levels;

   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         thr_ff[tbl_wr.idx]  <= tbl_wr.thr;
         code_ff[tbl_wr.idx] <= tbl_wr.code;
      end
   end

   assign levels = (IDX_W+1)'(1) << k_eff;

   // entry 0 is never compared
   always_comb begin
      below[0] = 1'b0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         below[i] = ((IDX_W+1)'(i) < levels) &&
                    ($signed(thr_ff[i]) < $signed(sample));
      end
   end

   always_comb begin
      level = '0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         level = level + IDX_W'(below[i]);
      end
   end

   assign code = code_ff[level];

endmodule

@@ rtl/threshold_quantize_bitplane_pack.sv @@
// Threshold quantiser and bit-plane packer: top level with CSRs and output buffer.
`include "threshold_quantize_bitplane_pack_macros.svh"

// Each req beat either loads one entry of the threshold/code tables (tuser 0)
// or delivers one signed Q16.16 sample (tuser 1). A sample is compared
// against thresholds 1..2^k-1 in parallel, its k-bit code is looked up and
// ORed into the bit-plane words. A sample's code bits go from the input
// register into the plane accumulators, and one beat can be accepted every
// cycle. After the 32nd sample of a group, or the last of a vector, k words
// go out on rsp, one per cycle while rsp_tready is high, from a snapshot
// buffer while further samples keep arriving; the input stalls only when a
// group closes before the previous group's words have all been taken (for
// example with very short vectors), so the sustained rate is one sample per
// cycle while groups are at least k samples long. The tables are flip-flops
// with no reset: load every entry a sample can reach before sending samples.
module threshold_quantize_bitplane_pack #(
   parameter int MAX_BITS   = tqbp_pkg::MAX_BITS_DEF,
   parameter int MAX_LENGTH = tqbp_pkg::MAX_LENGTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: entry_index[3:0], threshold[35:4], level_code[39:36], sample[71:40]
   input  logic [tqbp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,  // opcode
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: plane[1:0], word_index[6:2], packed_word[38:7], zero[39]
   output logic [tqbp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // vector_end
   output logic                               rsp_tlast,  // last_of_run
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tqbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tqbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tqbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import tqbp_pkg::*;

   localparam int KMAX  = (MAX_BITS < TABLE_KMAX) ? MAX_BITS : TABLE_KMAX;
   localparam int POS_W = $clog2(MAX_LENGTH);
   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam int LW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

   // configuration
   logic [BITS_CFG_W-1:0] bits_used_ff, bits_used_in;
   logic [LEN_CFG_W-1:0]  vec_len_ff, vec_len_in;
   logic                  csr_wr;

   // input register
   logic              in_valid_ff, in_valid_in;
   op_type            in_op_ff;
   logic [IDX_W-1:0]  in_idx_ff;
   logic [DATA_W-1:0] in_thr_ff;
   logic [CODE_W-1:0] in_code_ff;
   logic [DATA_W-1:0] in_smp_ff;

   // sample state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] acc_ff [KMAX];
   logic [WORD_W-1:0] acc_in [KMAX];
   logic [WORD_W-1:0] snap   [KMAX];

   // output buffer
   logic                  out_valid_ff, out_valid_in;
   logic [PLANE_W-1:0]    plane_ff, plane_in;
   logic [BITS_CFG_W-1:0] planes_ff;
   logic [WIDX_W-1:0]     widx_ff;
   logic                  vend_ff;
   logic [WORD_W-1:0]     buf_ff [KMAX];

   logic [BITS_CFG_W-1:0] k_eff;
   logic [LW-1:0]         len_eff, pos_next;
   logic [POS_W+GRP_W-1:0] pos_x;
   logic [CODE_W-1:0]     code;
   logic [KMAX-1:0]       code_bit;
   logic                  is_sample, vec_end, grp_end;
   logic                  last_beat, buf_free, proc_fire, emit, rsp_take;
   logic [WORD_W-1:0]     rsp_word;
   tbl_wr_type            tbl_wr;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bits_used_in = bits_used_ff;
      vec_len_in   = vec_len_ff;
      if (csr_wr) begin
         case (reg_type'(csr_paddr[2]))
            REG_BITS_USED:     bits_used_in = csr_pwdata[BITS_CFG_W-1:0];
            REG_VECTOR_LENGTH: vec_len_in   = csr_pwdata[LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_type'(csr_paddr[2]))
         REG_BITS_USED:     csr_prdata = CSR_DATA_W'(bits_used_ff);
         REG_VECTOR_LENGTH: csr_prdata = CSR_DATA_W'(vec_len_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_used_ff <= BITS_USED_RST;
         vec_len_ff   <= VECTOR_LENGTH_RST;
      end else begin
         bits_used_ff <= bits_used_in;
         vec_len_ff   <= vec_len_in;
      end
   end

   // clamped k and vector length
   always_comb begin
      k_eff = bits_used_ff;
      if (k_eff == '0) k_eff = BITS_CFG_W'(1);
      if (k_eff > BITS_CFG_W'(KMAX)) k_eff = BITS_CFG_W'(KMAX);
      len_eff = LW'(vec_len_ff);
      if (len_eff == '0) len_eff = LW'(1);
      if (len_eff > LW'(MAX_LENGTH)) len_eff = LW'(MAX_LENGTH);
   end

   // ---------------- sample stage ----------------
   assign is_sample = in_valid_ff && (in_op_ff == OP_SAMPLE);
   assign pos_next  = LW'(pos_ff) + LW'(1);
   assign vec_end   = pos_next >= len_eff;
   assign grp_end   = (pos_ff[GRP_W-1:0] == {GRP_W{1'b1}}) || vec_end;
   assign pos_x     = (POS_W+GRP_W)'(pos_ff);

   assign last_beat = ({1'b0, plane_ff} + BITS_CFG_W'(1)) == planes_ff;
   assign rsp_take  = out_valid_ff && rsp_tready;
   assign buf_free  = !out_valid_ff || (rsp_tready && last_beat);
   assign proc_fire = in_valid_ff && (!(is_sample && grp_end) || buf_free);
   assign emit      = proc_fire && is_sample && grp_end;
   assign req_tready = !in_valid_ff || proc_fire;

   assign tbl_wr.we   = proc_fire && (in_op_ff == OP_TABLE_WRITE);
   assign tbl_wr.idx  = in_idx_ff;
   assign tbl_wr.thr  = in_thr_ff;
   assign tbl_wr.code = in_code_ff;

   tqbp_level u_level (
      .clock  (clock),
      .tbl_wr (tbl_wr),
      .sample (in_smp_ff),
      .k_eff  (k_eff),
      .code   (code)
   );

   always_comb begin
      for (int b = 0; b < KMAX; b++) begin
         code_bit[b] = code[b] && (BITS_CFG_W'(b) < k_eff);
         snap[b]     = acc_ff[b] | (WORD_W'(code_bit[b]) << pos_ff[GRP_W-1:0]);
         if (emit) begin
            acc_in[b] = '0;
         end else if (proc_fire && is_sample) begin
            acc_in[b] = snap[b];
         end else begin
            acc_in[b] = acc_ff[b];
         end
      end
   end

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      pos_in = pos_ff;
      if (proc_fire && is_sample) begin
         pos_in = vec_end ? '0 : pos_next[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         for (int b = 0; b < KMAX; b++) acc_ff[b] <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         for (int b = 0; b < KMAX; b++) acc_ff[b] <= acc_in[b];
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= op_type'(req_tuser);
         in_idx_ff  <= req_tdata[IDX_W-1:0];
         in_thr_ff  <= req_tdata[IDX_W+DATA_W-1:IDX_W];
         in_code_ff <= req_tdata[IDX_W+DATA_W+CODE_W-1:IDX_W+DATA_W];
         in_smp_ff  <= req_tdata[REQ_DATA_W-1:IDX_W+DATA_W+CODE_W];
      end
   end

   // ---------------- output buffer ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      plane_in     = plane_ff;
      if (rsp_take) begin
         if (last_beat) out_valid_in = 1'b0;
         else           plane_in     = plane_ff + PLANE_W'(1);
      end
      if (emit) begin
         out_valid_in = 1'b1;
         plane_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         plane_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         plane_ff     <= plane_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         planes_ff <= k_eff;
         widx_ff   <= pos_x[GRP_W+WIDX_W-1:GRP_W];
         vend_ff   <= vec_end;
         for (int b = 0; b < KMAX; b++) buf_ff[b] <= snap[b];
      end
   end

   always_comb begin
      rsp_word = '0;
      for (int b = 0; b < KMAX; b++) begin
         if (plane_ff == PLANE_W'(b)) rsp_word = buf_ff[b];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_word, widx_ff, plane_ff};
   assign rsp_tlast  = last_beat;
   assign rsp_tuser  = vend_ff;

   // ---------------- assertions ----------------
   `TQBP_ASSERT(a_plane_in_range, out_valid_ff |-> ({1'b0, plane_ff} < planes_ff), "plane beyond used planes")
   `TQBP_ASSERT(a_acc_cleared, emit |=> (acc_ff[0] == '0), "accumulator not cleared after emission")
   `TQBP_ASSERT(a_no_overwrite, emit |-> buf_free, "output buffer overwritten before drained")
   `TQBP_ASSERT_RST(a_reset_idle, reset |=> (!out_valid_ff && !in_valid_ff), "not idle after reset")

endmodule
